>>> design/vn2ds_pkg.sv
// ----------------------------------------------------------------------------
// vn2ds_pkg
// Shared types and constants of the 2D value-noise sampler: hash multipliers,
// field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package vn2ds_pkg;

    localparam int COORD_IN_W = 16;
    localparam int SCALE_W    = 16;
    localparam int SEED_W     = 32;
    localparam int HASH_W     = 24;
    localparam int HASH_SHIFT = 13;

    localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
    localparam logic [31:0] HASH_MUL_SEED = 32'd3266489917;
    localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;

    localparam logic [SEED_W-1:0]  SEED_RST  = 32'd311;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd200;

    // The seed enters every hash only through its product, so that product is
    // what the block stores.
    localparam logic [31:0] SEED_TERM_RST = 32'(64'(SEED_RST) * 64'(HASH_MUL_SEED));

    typedef enum logic [0:0] {
        CFG_NOISE_SEED = 1'b0,
        CFG_CELL_SCALE = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

>>> design/value_noise_2d_sampler_core.sv
// ----------------------------------------------------------------------------
// value_noise_2d_sampler_core
// Smooth 2D value noise: long division of each coordinate by the cell size,
// seeded corner hashes, quintic fade and bilinear blend in fixed point.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless stalled; the divider takes one
// quotient bit per stage; the hash, fade and blend units are pipelined behind it.
// A held result stalls the whole pipeline; input is taken when it moves.
// Reset clears all valid bits and restores noise_seed to 311, cell_scale to 200.
`default_nettype none

module value_noise_2d_sampler_core #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [vn2ds_pkg::COORD_IN_W-1:0]    i_x_coord,
    input  wire  [vn2ds_pkg::COORD_IN_W-1:0]    i_y_coord,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [vn2ds_pkg::HASH_W-1:0]        o_noise_value,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  vn2ds_pkg::t_cfg_index               i_cfg_index,
    input  wire  [vn2ds_pkg::SEED_W-1:0]        i_cfg_data
);
    import vn2ds_pkg::*;

    localparam int DIV_STEPS = COORD_WIDTH + FRAC_BITS;
    localparam int NST       = DIV_STEPS + 7;
    localparam int ST_F3     = DIV_STEPS + 2;
    localparam int PW_F      = FRAC_BITS + 5;
    localparam int MW_F      = 2 * FRAC_BITS + 6;
    localparam int PRW       = FRAC_BITS + 27;

    localparam logic signed [PW_F-1:0] P_OFFS = PW_F'(15 * (2 ** FRAC_BITS));
    localparam logic signed [PW_F-1:0] Q_OFFS = PW_F'(10 * (2 ** FRAC_BITS));
    localparam logic [FRAC_BITS:0]     FADE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [31:0]        r_seed_term;
    logic [SCALE_W-1:0] r_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_term <= SEED_TERM_RST;
            r_scale     <= SCALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NOISE_SEED: r_seed_term <= i_cfg_data * HASH_MUL_SEED;
                CFG_CELL_SCALE: begin
                    // A zero cell size behaves as a size of one.
                    if (i_cfg_data[SCALE_W-1:0] == '0) begin
                        r_scale <= SCALE_W'(1);
                    end else begin
                        r_scale <= i_cfg_data[SCALE_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic           w_adv;
    logic [NST-1:0] r_vld;

    assign w_adv       = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: (coord << FRAC_BITS) / scale, one bit per stage.
    // The upper COORD_WIDTH quotient bits are the lattice index, the lower
    // FRAC_BITS bits the fraction.
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] w_dividend [2];
    logic [SCALE_W-1:0]   n_rem [2][DIV_STEPS];
    logic [DIV_STEPS-1:0] n_dq  [2][DIV_STEPS];
    logic [SCALE_W-1:0]   r_rem [2][DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dq  [2][DIV_STEPS];

    assign w_dividend[0] = {COORD_WIDTH'(i_x_coord), {FRAC_BITS{1'b0}}};
    assign w_dividend[1] = {COORD_WIDTH'(i_y_coord), {FRAC_BITS{1'b0}}};

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [SCALE_W-1:0]   w_rem_in;
            logic [DIV_STEPS-1:0] w_dq_in;
            logic [SCALE_W:0]     w_sh;
            logic                 w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_dq_in  = w_dividend[l];
            end else begin : g_next
                assign w_rem_in = r_rem[l][k-1];
                assign w_dq_in  = r_dq[l][k-1];
            end

            assign w_sh = {w_rem_in, w_dq_in[DIV_STEPS-1]};
            assign w_ge = w_sh >= {1'b0, r_scale};
            assign n_rem[l][k] = w_ge ? SCALE_W'(w_sh - {1'b0, r_scale})
                                      : w_sh[SCALE_W-1:0];
            assign n_dq[l][k]  = {w_dq_in[DIV_STEPS-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < DIV_STEPS; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_dq[l][k]  <= n_dq[l][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Corner hashes (three stages) and quintic fade (three stages).
    // Corner c: bit 0 selects ix+1, bit 1 selects iy+1.
    // ------------------------------------------------------------------
    logic [31:0]           w_cidx [2];
    logic [FRAC_BITS-1:0]  w_t [2];
    logic [31:0]           n_h1_x [2];
    logic [31:0]           n_h1_y [2];
    logic [31:0]           r_h1_x [2];
    logic [31:0]           r_h1_y [2];
    logic [31:0]           n_h2 [4];
    logic [31:0]           r_h2 [4];
    logic [31:0]           w_mix [4];
    logic [HASH_W-1:0]     n_h3 [4];
    logic [HASH_W-1:0]     r_h3 [4];

    logic [FRAC_BITS+2:0]    w_t6 [2];
    logic [2*FRAC_BITS-1:0]  w_sq [2];
    logic signed [PW_F-1:0]  n_f1_p [2];
    logic [FRAC_BITS-1:0]    n_f1_t2 [2];
    logic signed [PW_F-1:0]  r_f1_p [2];
    logic [FRAC_BITS-1:0]    r_f1_t2 [2];
    logic [FRAC_BITS-1:0]    r_f1_t [2];
    logic signed [MW_F-1:0]  w_tp [2];
    logic [2*FRAC_BITS-1:0]  w_t2t [2];
    logic signed [PW_F-1:0]  n_f2_q [2];
    logic [FRAC_BITS-1:0]    n_f2_t3 [2];
    logic signed [PW_F-1:0]  r_f2_q [2];
    logic [FRAC_BITS-1:0]    r_f2_t3 [2];
    logic signed [MW_F-1:0]  w_tq [2];
    logic [FRAC_BITS:0]      n_f3_fade [2];
    logic [FRAC_BITS:0]      r_f3_fade [2];

    always_comb begin
        // Both lattice indexes are needed by both lanes of the first hash stage.
        for (int l = 0; l < 2; l++) begin
            w_cidx[l] = 32'(r_dq[l][DIV_STEPS-1][DIV_STEPS-1:FRAC_BITS]);
            w_t[l]    = r_dq[l][DIV_STEPS-1][FRAC_BITS-1:0];
        end
        for (int l = 0; l < 2; l++) begin
            n_h1_x[l] = (w_cidx[0] + 32'(l)) * HASH_MUL_X;
            n_h1_y[l] = (w_cidx[1] + 32'(l)) * HASH_MUL_Y;

            // p = 6t - 15 in signed Q4.FRAC_BITS, t2 = t*t in Q0.FRAC_BITS.
            w_t6[l]    = {1'b0, w_t[l], 2'b00} + {2'b00, w_t[l], 1'b0};
            n_f1_p[l]  = $signed({2'b00, w_t6[l]}) - P_OFFS;
            w_sq[l]    = w_t[l] * w_t[l];
            n_f1_t2[l] = w_sq[l][2*FRAC_BITS-1:FRAC_BITS];

            // q = t*p + 10 and t3 = t2*t; the arithmetic shift floors.
            w_tp[l]    = $signed({1'b0, r_f1_t[l]}) * r_f1_p[l];
            n_f2_q[l]  = PW_F'(w_tp[l] >>> FRAC_BITS) + Q_OFFS;
            w_t2t[l]   = r_f1_t2[l] * r_f1_t[l];
            n_f2_t3[l] = w_t2t[l][2*FRAC_BITS-1:FRAC_BITS];

            w_tq[l]      = $signed({1'b0, r_f2_t3[l]}) * r_f2_q[l];
            n_f3_fade[l] = (FRAC_BITS+1)'(w_tq[l] >>> FRAC_BITS);
        end
        for (int c = 0; c < 4; c++) begin
            n_h2[c]  = r_h1_x[c % 2] + r_h1_y[c / 2] + r_seed_term;
            w_mix[c] = r_h2[c] ^ (r_h2[c] >> HASH_SHIFT);
            n_h3[c]  = HASH_W'(w_mix[c] * HASH_MUL_MIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 2; l++) begin
                r_h1_x[l]    <= n_h1_x[l];
                r_h1_y[l]    <= n_h1_y[l];
                r_f1_t[l]    <= w_t[l];
                r_f1_p[l]    <= n_f1_p[l];
                r_f1_t2[l]   <= n_f1_t2[l];
                r_f2_q[l]    <= n_f2_q[l];
                r_f2_t3[l]   <= n_f2_t3[l];
                r_f3_fade[l] <= n_f3_fade[l];
            end
            for (int c = 0; c < 4; c++) begin
                r_h2[c] <= n_h2[c];
                r_h3[c] <= n_h3[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend: rows along x (two stages), then the rows along y (two stages).
    // Row 0 is the top row (corners 0 and 1), row 1 the bottom row.
    // ------------------------------------------------------------------
    logic signed [HASH_W:0]  w_b1_d [2];
    logic signed [PRW-1:0]   n_b1_prod [2];
    logic signed [PRW-1:0]   r_b1_prod [2];
    logic [HASH_W-1:0]       r_b1_a [2];
    logic [FRAC_BITS:0]      r_b1_fy;
    logic signed [PRW-1:0]   w_b2_shr [2];
    logic [HASH_W-1:0]       n_b2_row [2];
    logic [HASH_W-1:0]       r_b2_row [2];
    logic [FRAC_BITS:0]      r_b2_fy;
    logic signed [HASH_W:0]  w_b3_d;
    logic signed [PRW-1:0]   n_b3_prod;
    logic signed [PRW-1:0]   r_b3_prod;
    logic [HASH_W-1:0]       r_b3_top;
    logic signed [PRW-1:0]   w_b4_shr;
    logic [HASH_W-1:0]       n_out;
    logic [HASH_W-1:0]       r_out;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            w_b1_d[r]    = $signed({1'b0, r_h3[2*r+1]}) - $signed({1'b0, r_h3[2*r]});
            n_b1_prod[r] = $signed({1'b0, r_f3_fade[0]}) * w_b1_d[r];
            w_b2_shr[r]  = r_b1_prod[r] >>> FRAC_BITS;
            n_b2_row[r]  = HASH_W'(PRW'(r_b1_a[r]) + w_b2_shr[r]);
        end
        w_b3_d    = $signed({1'b0, r_b2_row[1]}) - $signed({1'b0, r_b2_row[0]});
        n_b3_prod = $signed({1'b0, r_b2_fy}) * w_b3_d;
        w_b4_shr  = r_b3_prod >>> FRAC_BITS;
        // A fade within [0, 1] keeps the blend between its two corners.
        n_out     = HASH_W'(PRW'(r_b3_top) + w_b4_shr);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 2; r++) begin
                r_b1_prod[r] <= n_b1_prod[r];
                r_b1_a[r]    <= r_h3[2*r];
                r_b2_row[r]  <= n_b2_row[r];
            end
            r_b1_fy   <= r_f3_fade[1];
            r_b2_fy   <= r_b1_fy;
            r_b3_prod <= n_b3_prod;
            r_b3_top  <= r_b2_row[0];
            r_out     <= n_out;
        end
    end

    assign o_noise_value = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scale != '0)
        else $error("divider scale is zero");

    a_fade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_F3] |-> (r_f3_fade[0] <= FADE_ONE) && (r_f3_fade[1] <= FADE_ONE))
        else $error("fade weight exceeds one");

endmodule

`default_nettype wire
